/* sv/lidar_range_jump_segmenter_assert.svh */
// assertion macros for the lidar range-jump segmenter
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef LIDAR_RANGE_JUMP_SEGMENTER_ASSERT_SVH
`define LIDAR_RANGE_JUMP_SEGMENTER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segmenter implication check failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segmenter next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* sv/lrjs_pkg.sv */
// shared types, constants and the trig table for the range-jump segmenter
// no dependencies
package lrjs_pkg;

   localparam int MAX_BEAMS        = 4096;
   localparam int BEAM_BITS        = $clog2(MAX_BEAMS);
   localparam int LEN_BITS         = BEAM_BITS + 1;
   localparam int TRIG_TABLE_DEPTH = 256;
   localparam int TRIG_BITS        = $clog2(TRIG_TABLE_DEPTH);

   // result field widths
   localparam int START_W = 12;
   localparam int SEGLEN_W = 13;

   // record kinds
   localparam logic REC_SEGMENT = 1'b0;
   localparam logic REC_END     = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_COMPARE_MODE = 3'd0;
   localparam logic [2:0] CSR_MIN_LENGTH   = 3'd1;
   localparam logic [2:0] CSR_OFFSET_MM    = 3'd2;
   localparam logic [2:0] CSR_GAIN_Q16     = 3'd3;
   localparam logic [2:0] CSR_RADIUS_MM    = 3'd4;
   localparam logic [2:0] CSR_FIXED_STEP   = 3'd5;
   localparam logic [2:0] CSR_WRAP_ENABLE  = 3'd6;

   // compare modes
   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_CIRCLE = 1'b1;

   // register reset values
   localparam logic [12:0] MIN_LENGTH_RST = 13'd1;
   localparam logic [15:0] OFFSET_RST     = 16'd100;
   localparam logic [15:0] GAIN_RST       = 16'd6554;
   localparam logic [15:0] RADIUS_RST     = 16'd100;

   // continuity test request and answer
   typedef struct packed {
      logic        start;
      logic [15:0] r0;
      logic [15:0] r1;
      logic [15:0] alpha;
   } test_req_type;

   typedef struct packed {
      logic done;
      logic pass;
   } test_rsp_type;

   typedef struct packed {
      logic        mode;
      logic [15:0] offset;
      logic [15:0] gain;
      logic [15:0] radius;
   } test_cfg_type;

   // cordic arctangent steps in units of 2pi/2^32
   localparam longint ATAN_TURNS [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
      5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81
   };

   typedef logic [31:0] trig_rom_type [TRIG_TABLE_DEPTH];

   // one table entry: cos in the upper half, sin in the lower, both q14
   function automatic logic [31:0] trig_entry(input int k);
      longint unsigned ang;
      longint          x;
      longint          y;
      longint          z;
      longint          dx;
      longint          dy;
      longint          cx;
      longint          sy;
      longint          c;
      longint          s;
      logic [1:0]      quad;
      ang  = longint'(k) << (32 - TRIG_BITS);
      quad = ang[31:30];
      x    = 652032874;
      y    = 0;
      z    = longint'(ang & 64'h3FFF_FFFF);
      for (int i = 0; i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TURNS[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TURNS[i];
         end
      end
      cx = (x + 32768) >>> 16;
      sy = (y + 32768) >>> 16;
      case (quad)
         2'd0: begin c = cx;  s = sy;  end
         2'd1: begin c = -sy; s = cx;  end
         2'd2: begin c = -cx; s = -sy; end
         default: begin c = sy; s = -cx; end
      endcase
      return {c[15:0], s[15:0]};
   endfunction

   function automatic trig_rom_type build_trig_rom();
      trig_rom_type rom;
      for (int k = 0; k < TRIG_TABLE_DEPTH; k++) begin
         rom[k] = trig_entry(k);
      end
      return rom;
   endfunction

   localparam trig_rom_type TRIG_ROM = build_trig_rom();

endpackage

/* sv/lrjs_test_unit.sv */
// continuity test: one shared 32x32 multiplier stepped by a small sequencer
// depends on lrjs_pkg
module lrjs_test_unit import lrjs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  test_cfg_type cfg,
   input  test_req_type req,
   output test_rsp_type rsp
);

   typedef enum logic [12:0] {
      S_IDLE    = 13'b0000000000001,
      S_LIN_MUL = 13'b0000000000010,
      S_LIN_CMP = 13'b0000000000100,
      S_M1      = 13'b0000000001000,
      S_D       = 13'b0000000010000,
      S_DSQ     = 13'b0000000100000,
      S_R0SQ    = 13'b0000001000000,
      S_SSQ     = 13'b0000010000000,
      S_PROD    = 13'b0000100000000,
      S_RSQ     = 13'b0001000000000,
      S_U       = 13'b0010000000000,
      S_CMP     = 13'b0100000000000,
      S_DONE    = 13'b1000000000000
   } tstate_type;

   tstate_type         state_ff, state_in;
   logic [15:0]        r0_ff, r0_in, r1_ff, r1_in;
   logic signed [15:0] cos_ff, cos_in, sin_ff, sin_in;
   logic [63:0]        prod_ff, prod_in;
   logic [31:0]        dabs_ff, dabs_in;
   logic [63:0]        dsq_ff, dsq_in;
   logic [31:0]        r0sq_ff, r0sq_in;
   logic [63:0]        rs_ff, rs_in;
   logic [63:0]        u_ff, u_in;
   logic               pass_ff, pass_in;

   logic [31:0]        mul_a, mul_b;
   logic [31:0]        ang_scaled;
   logic [TRIG_BITS-1:0] trig_idx;
   logic [31:0]        trig_word;
   logic [15:0]        diff, lo;
   logic [32:0]        lin_rhs;
   logic signed [17:0] cterm;
   logic signed [16:0] rdiff;
   logic signed [33:0] dval;
   logic [15:0]        sabs;

   // nearest table step for the requested angle
   assign ang_scaled = (32'(req.alpha) << TRIG_BITS) + 32'd32768;
   assign trig_idx   = ang_scaled[16 +: TRIG_BITS];
   assign trig_word  = TRIG_ROM[trig_idx];

   // operand prep
   assign diff    = (r1_ff > r0_ff) ? (r1_ff - r0_ff) : (r0_ff - r1_ff);
   assign lo      = (r1_ff < r0_ff) ? r1_ff : r0_ff;
   assign lin_rhs = {1'b0, cfg.offset, 16'd0} + {1'b0, prod_ff[31:0]};
   assign cterm   = 18'sd16384 - 18'(cos_ff);
   assign rdiff   = $signed({1'b0, r1_ff}) - $signed({1'b0, r0_ff});
   assign dval    = (34'(rdiff) <<< 14) + $signed({2'b00, prod_ff[31:0]});
   assign sabs    = sin_ff[15] ? 16'(-sin_ff) : 16'(sin_ff);

   // shared multiplier operand select
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (state_ff)
         S_LIN_MUL: begin mul_a = 32'(lo);           mul_b = 32'(cfg.gain);   end
         S_M1:      begin mul_a = 32'(r0_ff);        mul_b = 32'(cterm[16:0]); end
         S_DSQ:     begin mul_a = dabs_ff;           mul_b = dabs_ff;         end
         S_R0SQ:    begin mul_a = 32'(r0_ff);        mul_b = 32'(r0_ff);      end
         S_SSQ:     begin mul_a = 32'(sabs);         mul_b = 32'(sabs);       end
         S_PROD:    begin mul_a = r0sq_ff;           mul_b = prod_ff[31:0];   end
         S_RSQ:     begin mul_a = 32'(cfg.radius);   mul_b = 32'(cfg.radius); end
         default:   begin mul_a = 32'd0;             mul_b = 32'd0;           end
      endcase
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // sequencer
   always_comb begin
      state_in = state_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      dabs_in  = dabs_ff;
      dsq_in   = dsq_ff;
      r0sq_in  = r0sq_ff;
      rs_in    = rs_ff;
      u_in     = u_ff;
      pass_in  = pass_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               r0_in  = req.r0;
               r1_in  = req.r1;
               cos_in = $signed(trig_word[31:16]);
               sin_in = $signed(trig_word[15:0]);
               if (req.r0 == 16'd0 || req.r1 == 16'd0) begin
                  pass_in  = 1'b0;
                  state_in = S_DONE;
               end else if (cfg.mode == MODE_LINEAR) begin
                  state_in = S_LIN_MUL;
               end else begin
                  state_in = S_M1;
               end
            end
         end
         S_LIN_MUL: state_in = S_LIN_CMP;
         S_LIN_CMP: begin
            pass_in  = ({1'b0, diff, 16'd0} <= lin_rhs);
            state_in = S_DONE;
         end
         S_M1: state_in = S_D;
         S_D: begin
            dabs_in  = dval[33] ? 32'(-dval) : 32'(dval);
            state_in = S_DSQ;
         end
         S_DSQ: state_in = S_R0SQ;
         S_R0SQ: begin
            dsq_in   = prod_ff;
            state_in = S_SSQ;
         end
         S_SSQ: begin
            r0sq_in  = prod_ff[31:0];
            state_in = S_PROD;
         end
         S_PROD: state_in = S_RSQ;
         S_RSQ: begin
            rs_in    = prod_ff;
            state_in = S_U;
         end
         S_U: begin
            u_in     = {2'b00, prod_ff[31:0], 30'd0} - rs_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            pass_in  = !u_ff[63] && (dsq_ff <= u_ff);
            state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
      prod_ff <= prod_in;
      dabs_ff <= dabs_in;
      dsq_ff  <= dsq_in;
      r0sq_ff <= r0sq_in;
      rs_ff   <= rs_in;
      u_ff    <= u_in;
   end

   assign rsp.done = (state_ff == S_DONE);
   assign rsp.pass = pass_ff;

endmodule

/* sv/lidar_range_jump_segmenter.sv */
// lidar range-jump segmenter top level: beam bookkeeping, records, csr
// depends on lrjs_pkg, lrjs_test_unit and lidar_range_jump_segmenter_assert.svh
//
// channel   dir   handshake               contents
// req       in    req_tvalid/req_tready    one beam: range, bearing, scan end
// rsp       out   rsp_tvalid/rsp_tready    segment or end-of-scan record
// csr       in    csr_valid/csr_ready      register index and write data
//
// a beam that opens a segment passes idle and advance; a continuity test adds the
// linear or circle sequence of the shared multiplier (a zero range skips to done),
// and a break adds the break state. a scan end adds close, wrap start and end, plus
// the wrap check. req_tready is high only while no beam is in work; a held rsp record
// stalls the sequencer before the next record. reset is synchronous, no clearing pass.
`include "lidar_range_jump_segmenter_assert.svh"
module lidar_range_jump_segmenter import lrjs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // range_mm [15:0], bearing [31:16]
   input  logic        req_tlast,   // scan_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // start_index [11:0], seg_length [24:12],
                                    // wrap_joined [25], zero [31:26]
   output logic        rsp_tuser,   // record_kind
   output logic        rsp_tlast,   // final_flag
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   typedef enum logic [7:0] {
      P_IDLE       = 8'b00000001,
      P_TEST       = 8'b00000010,
      P_BREAK      = 8'b00000100,
      P_ADV        = 8'b00001000,
      P_LCLOSE     = 8'b00010000,
      P_WRAP_START = 8'b00100000,
      P_WRAP_WAIT  = 8'b01000000,
      P_END        = 8'b10000000
   } pstate_type;

   // configuration
   logic        mode_ff;
   logic [12:0] min_length_ff;
   logic [15:0] offset_ff, gain_ff, radius_ff, fixed_step_ff;
   logic        wrap_en_ff;

   // scan state
   pstate_type           state_ff, state_in;
   logic [15:0]          prior_range_ff, prior_range_in, prior_bearing_ff, prior_bearing_in;
   logic [BEAM_BITS-1:0] beam_count_ff, beam_count_in, open_start_ff, open_start_in;
   logic [LEN_BITS-1:0]  open_length_ff, open_length_in;
   logic [1:0]           kept_ff, kept_in;
   logic [15:0]          head_range_ff, head_range_in, head_bearing_ff, head_bearing_in;
   logic [15:0]          tail_range_ff, tail_range_in, tail_bearing_ff, tail_bearing_in;
   logic [15:0]          beam_range_ff, beam_range_in, beam_bearing_ff, beam_bearing_in;
   logic                 beam_last_ff, beam_last_in;
   logic                 joined_ff, joined_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [START_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [SEGLEN_W-1:0] rsp_len_ff, rsp_len_in;
   logic                rsp_wrap_ff, rsp_wrap_in;
   logic                rsp_last_ff, rsp_last_in;

   test_cfg_type tcfg;
   test_req_type treq;
   test_rsp_type trsp;

   logic        req_fire, slot_free, seg_close;
   logic [1:0]  kept_inc, kept_after;
   logic [15:0] req_range, req_bearing;

   assign req_range   = req_tdata[15:0];
   assign req_bearing = req_tdata[31:16];
   assign req_tready  = (state_ff == P_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign seg_close   = (13'(open_length_ff) >= min_length_ff);
   assign kept_inc    = (kept_ff == 2'd2) ? 2'd2 : kept_ff + 2'd1;
   assign kept_after  = seg_close ? kept_inc : kept_ff;

   // register writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_LINEAR;
         min_length_ff <= MIN_LENGTH_RST;
         offset_ff     <= OFFSET_RST;
         gain_ff       <= GAIN_RST;
         radius_ff     <= RADIUS_RST;
         fixed_step_ff <= 16'd0;
         wrap_en_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COMPARE_MODE: mode_ff       <= csr_data[0];
            CSR_MIN_LENGTH:   min_length_ff <= csr_data[12:0];
            CSR_OFFSET_MM:    offset_ff     <= csr_data;
            CSR_GAIN_Q16:     gain_ff       <= csr_data;
            CSR_RADIUS_MM:    radius_ff     <= csr_data;
            CSR_FIXED_STEP:   fixed_step_ff <= csr_data;
            CSR_WRAP_ENABLE:  wrap_en_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign tcfg.mode   = mode_ff;
   assign tcfg.offset = offset_ff;
   assign tcfg.gain   = gain_ff;
   assign tcfg.radius = radius_ff;

   lrjs_test_unit u_test (
      .clock (clock),
      .reset (reset),
      .cfg   (tcfg),
      .req   (treq),
      .rsp   (trsp)
   );

   // beam sequencer
   always_comb begin
      state_in         = state_ff;
      prior_range_in   = prior_range_ff;
      prior_bearing_in = prior_bearing_ff;
      beam_count_in    = beam_count_ff;
      open_start_in    = open_start_ff;
      open_length_in   = open_length_ff;
      kept_in          = kept_ff;
      head_range_in    = head_range_ff;
      head_bearing_in  = head_bearing_ff;
      tail_range_in    = tail_range_ff;
      tail_bearing_in  = tail_bearing_ff;
      beam_range_in    = beam_range_ff;
      beam_bearing_in  = beam_bearing_ff;
      beam_last_in     = beam_last_ff;
      joined_in        = joined_ff;
      treq.start       = 1'b0;
      treq.r0          = prior_range_ff;
      treq.r1          = req_range;
      treq.alpha       = (fixed_step_ff != 16'd0) ? fixed_step_ff
                                                  : req_bearing - prior_bearing_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_kind_in      = rsp_kind_ff;
      rsp_start_in     = rsp_start_ff;
      rsp_len_in       = rsp_len_ff;
      rsp_wrap_in      = rsp_wrap_ff;
      rsp_last_in      = rsp_last_ff;
      case (state_ff)
         P_IDLE: begin
            if (req_fire) begin
               beam_range_in   = req_range;
               beam_bearing_in = req_bearing;
               beam_last_in    = req_tlast;
               if (open_length_ff == '0) begin
                  open_start_in  = beam_count_ff;
                  open_length_in = LEN_BITS'(1);
                  if (kept_ff == 2'd0) begin
                     head_range_in   = req_range;
                     head_bearing_in = req_bearing;
                  end
                  state_in = P_ADV;
               end else begin
                  treq.start = 1'b1;
                  state_in   = P_TEST;
               end
            end
         end
         P_TEST: begin
            if (trsp.done) begin
               if (trsp.pass) begin
                  if (open_length_ff != LEN_BITS'(MAX_BEAMS)) begin
                     open_length_in = open_length_ff + LEN_BITS'(1);
                  end
                  state_in = P_ADV;
               end else begin
                  state_in = P_BREAK;
               end
            end
         end
         P_BREAK: begin
            if (!seg_close || slot_free) begin
               if (seg_close) begin
                  rsp_valid_in    = 1'b1;
                  rsp_kind_in     = REC_SEGMENT;
                  rsp_start_in    = START_W'(open_start_ff);
                  rsp_len_in      = SEGLEN_W'(open_length_ff);
                  rsp_wrap_in     = 1'b0;
                  rsp_last_in     = !beam_last_ff;
                  tail_range_in   = prior_range_ff;
                  tail_bearing_in = prior_bearing_ff;
               end
               kept_in        = kept_after;
               open_start_in  = beam_count_ff;
               open_length_in = LEN_BITS'(1);
               if (kept_after == 2'd0) begin
                  head_range_in   = beam_range_ff;
                  head_bearing_in = beam_bearing_ff;
               end
               state_in = P_ADV;
            end
         end
         P_ADV: begin
            prior_range_in   = beam_range_ff;
            prior_bearing_in = beam_bearing_ff;
            beam_count_in    = beam_count_ff + BEAM_BITS'(1);
            state_in         = beam_last_ff ? P_LCLOSE : P_IDLE;
         end
         P_LCLOSE: begin
            if (!seg_close || slot_free) begin
               if (seg_close) begin
                  rsp_valid_in    = 1'b1;
                  rsp_kind_in     = REC_SEGMENT;
                  rsp_start_in    = START_W'(open_start_ff);
                  rsp_len_in      = SEGLEN_W'(open_length_ff);
                  rsp_wrap_in     = 1'b0;
                  rsp_last_in     = 1'b0;
                  tail_range_in   = beam_range_ff;
                  tail_bearing_in = beam_bearing_ff;
               end
               kept_in  = kept_after;
               state_in = P_WRAP_START;
            end
         end
         P_WRAP_START: begin
            treq.r0    = tail_range_ff;
            treq.r1    = head_range_ff;
            treq.alpha = (fixed_step_ff != 16'd0) ? fixed_step_ff
                                                  : head_bearing_ff - tail_bearing_ff;
            if (wrap_en_ff && kept_ff == 2'd2) begin
               treq.start = 1'b1;
               state_in   = P_WRAP_WAIT;
            end else begin
               joined_in = 1'b0;
               state_in  = P_END;
            end
         end
         P_WRAP_WAIT: begin
            if (trsp.done) begin
               joined_in = trsp.pass;
               state_in  = P_END;
            end
         end
         P_END: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = REC_END;
               rsp_start_in   = '0;
               rsp_len_in     = '0;
               rsp_wrap_in    = joined_ff;
               rsp_last_in    = 1'b1;
               beam_count_in  = '0;
               open_start_in  = '0;
               open_length_in = '0;
               kept_in        = 2'd0;
               state_in       = P_IDLE;
            end
         end
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= P_IDLE;
         prior_range_ff   <= '0;
         prior_bearing_ff <= '0;
         beam_count_ff    <= '0;
         open_start_ff    <= '0;
         open_length_ff   <= '0;
         kept_ff          <= 2'd0;
         head_range_ff    <= '0;
         head_bearing_ff  <= '0;
         tail_range_ff    <= '0;
         tail_bearing_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         prior_range_ff   <= prior_range_in;
         prior_bearing_ff <= prior_bearing_in;
         beam_count_ff    <= beam_count_in;
         open_start_ff    <= open_start_in;
         open_length_ff   <= open_length_in;
         kept_ff          <= kept_in;
         head_range_ff    <= head_range_in;
         head_bearing_ff  <= head_bearing_in;
         tail_range_ff    <= tail_range_in;
         tail_bearing_ff  <= tail_bearing_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      beam_range_ff   <= beam_range_in;
      beam_bearing_ff <= beam_bearing_in;
      beam_last_ff    <= beam_last_in;
      joined_ff       <= joined_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_start_ff    <= rsp_start_in;
      rsp_len_ff      <= rsp_len_in;
      rsp_wrap_ff     <= rsp_wrap_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_wrap_ff, rsp_len_ff, rsp_start_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_fire, !req_tready)
   `ASSERT_IMPL(a_end_is_final, clock, reset, rsp_tvalid && rsp_tuser == REC_END, rsp_tlast)
   `ASSERT_IMPL(a_seg_nonempty, clock, reset, rsp_valid_ff && rsp_kind_ff == REC_SEGMENT, rsp_len_ff != '0)
   `ASSERT_IMPL(a_done_waiting, clock, reset, trsp.done, state_ff == P_TEST || state_ff == P_WRAP_WAIT)

endmodule

/* tb/sv/lidar_range_jump_segmenter_tb.sv */
// self-checking testbench for the lidar range-jump segmenter
// depends on lrjs_pkg and the lidar_range_jump_segmenter rtl
module lidar_range_jump_segmenter_tb import lrjs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] range_mm;
      logic [15:0] bearing;
      logic        scan_end;
   } beam_type;

   typedef struct {
      logic        kind;
      logic [11:0] start;
      logic [12:0] len;
      logic        wrap;
      logic        fin;
   } record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   lidar_range_jump_segmenter dut (.*);

   always #6 clock = ~clock;

   // beams waiting to be sent, records waiting to be seen
   beam_type   beam_q[$];
   record_type record_q[$];
   beam_type   cur_beam;
   int      fails = 0;
   int      tx_gap = 0;
   int      rx_gap = 0;
   int      hold_cnt = 0;
   bit      hold_req = 1'b0;
   bit      quiet = 1'b0;

   // register shadow
   logic        m_mode;
   logic [12:0] m_min_len;
   logic [15:0] m_offset, m_gain, m_radius, m_step;
   logic        m_wrap_en;

   // scan state shadow
   logic [15:0] s_prev_r, s_prev_b, s_head_r, s_head_b, s_tail_r, s_tail_b;
   int          s_count, s_open_start, s_open_len, s_kept;

   int cos_tab[TRIG_TABLE_DEPTH];
   int sin_tab[TRIG_TABLE_DEPTH];

   // cordic sine/cosine table, q14, nearest rounding of the q30 result
   task automatic fill_trig();
      longint atans[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
         21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      longint x, y, z, dx, dy, cx, sy;
      longint unsigned ang;
      for (int k = 0; k < TRIG_TABLE_DEPTH; k++) begin
         ang = (longint'(k) << 32) / TRIG_TABLE_DEPTH;
         x = 652032874;
         y = 0;
         z = longint'(ang & 64'h3FFF_FFFF);
         for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atans[i];
            end else begin
               x += dx; y -= dy; z += atans[i];
            end
         end
         cx = (x + 32768) >>> 16;
         sy = (y + 32768) >>> 16;
         case (ang[31:30])
            2'd0: begin cos_tab[k] = int'(cx);  sin_tab[k] = int'(sy);  end
            2'd1: begin cos_tab[k] = int'(-sy); sin_tab[k] = int'(cx);  end
            2'd2: begin cos_tab[k] = int'(-cx); sin_tab[k] = int'(-sy); end
            default: begin cos_tab[k] = int'(sy); sin_tab[k] = int'(-cx); end
         endcase
      end
   endtask

   // continuity between two beams
   function automatic bit is_continuous(logic [15:0] r0, logic [15:0] r1, logic [15:0] a);
      longint unsigned diff, lo, ad, idx;
      longint c, s, d, u, rr, a0;
      if (r0 == 0 || r1 == 0) return 1'b0;
      if (m_mode == MODE_LINEAR) begin
         diff = (r1 > r0) ? r1 - r0 : r0 - r1;
         lo = (r1 < r0) ? r1 : r0;
         return diff * 65536 <= longint'(m_offset) * 65536 + longint'(m_gain) * lo;
      end
      idx = ((longint'(a) * TRIG_TABLE_DEPTH + 32768) >> 16) % TRIG_TABLE_DEPTH;
      c = cos_tab[idx];
      s = sin_tab[idx];
      rr = m_radius;
      a0 = r0;
      d = (longint'(r1) - a0) * 16384 - a0 * (c - 16384);
      u = 4 * rr * rr * (64'sd1 <<< 28) - (a0 * a0) * (s * s);
      if (u < 0) return 1'b0;
      ad = (d < 0) ? -d : d;
      return ad * ad <= longint'(u);
   endfunction

   function automatic void push_record(logic kind, int start, int len, logic wrap);
      record_type rec;
      rec.kind = kind;
      rec.start = start[11:0];
      rec.len = len[12:0];
      rec.wrap = wrap;
      rec.fin = 1'b0;
      record_q.insert(record_q.size(), rec);
   endfunction

   function automatic void close_segment(logic [15:0] tr, logic [15:0] tb);
      if (s_open_len >= m_min_len) begin
         push_record(REC_SEGMENT, s_open_start, s_open_len, 1'b0);
         s_tail_r = tr;
         s_tail_b = tb;
         if (s_kept < 2) s_kept++;
      end
   endfunction

   // expected records for one accepted beam
   function automatic void segment_beam(beam_type bm);
      int          n0;
      logic [15:0] a;
      logic        joined;
      n0 = record_q.size();
      if (s_open_len == 0) begin
         s_open_start = s_count;
         s_open_len = 1;
         if (s_kept == 0) begin s_head_r = bm.range_mm; s_head_b = bm.bearing; end
      end else begin
         a = (m_step != 0) ? m_step : bm.bearing - s_prev_b;
         if (is_continuous(s_prev_r, bm.range_mm, a)) begin
            if (s_open_len < MAX_BEAMS) s_open_len++;
         end else begin
            close_segment(s_prev_r, s_prev_b);
            s_open_start = s_count;
            s_open_len = 1;
            if (s_kept == 0) begin s_head_r = bm.range_mm; s_head_b = bm.bearing; end
         end
      end
      s_prev_r = bm.range_mm;
      s_prev_b = bm.bearing;
      s_count = (s_count + 1) % MAX_BEAMS;
      if (bm.scan_end) begin
         joined = 1'b0;
         close_segment(bm.range_mm, bm.bearing);
         if (m_wrap_en && s_kept >= 2) begin
            a = (m_step != 0) ? m_step : s_head_b - s_tail_b;
            joined = is_continuous(s_tail_r, s_head_r, a);
         end
         push_record(REC_END, 0, 0, joined);
         s_count = 0;
         s_open_start = 0;
         s_open_len = 0;
         s_kept = 0;
      end
      if (record_q.size() > n0) record_q[record_q.size() - 1].fin = 1'b1;
   endfunction

   // sender: one beam transfer per handshake, random gaps after a beam
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) segment_beam(cur_beam);
         if (!req_tvalid || req_tready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_tvalid <= 1'b0;
            end else if (beam_q.size() > 0) begin
               cur_beam = beam_q.pop_front();
               req_tdata <= {cur_beam.bearing, cur_beam.range_mm};
               req_tlast <= cur_beam.scan_end;
               req_tvalid <= 1'b1;
               if (!quiet && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 5);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each record transfer, random stalls and one long hold
   always @(posedge clock) begin
      record_type rec;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (record_q.size() == 0) begin
               $error("unexpected record kind=%0d data=%h", rsp_tuser, rsp_tdata);
               fails++;
            end else begin
               rec = record_q.pop_front();
               if (rsp_tuser !== rec.kind) begin
                  $error("record_kind exp %0d got %0d", rec.kind, rsp_tuser); fails++;
               end
               if (rsp_tdata[11:0] !== rec.start) begin
                  $error("start_index exp %0d got %0d", rec.start, rsp_tdata[11:0]);
                  fails++;
               end
               if (rsp_tdata[24:12] !== rec.len) begin
                  $error("seg_length exp %0d got %0d", rec.len, rsp_tdata[24:12]);
                  fails++;
               end
               if (rsp_tdata[25] !== rec.wrap) begin
                  $error("wrap_joined exp %0d got %0d", rec.wrap, rsp_tdata[25]); fails++;
               end
               if (rsp_tlast !== rec.fin) begin
                  $error("final_flag exp %0d got %0d", rec.fin, rsp_tlast); fails++;
               end
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 400;
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 5);
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_COMPARE_MODE: m_mode = val[0];
         CSR_MIN_LENGTH:   m_min_len = val[12:0];
         CSR_OFFSET_MM:    m_offset = val;
         CSR_GAIN_Q16:     m_gain = val;
         CSR_RADIUS_MM:    m_radius = val;
         CSR_FIXED_STEP:   m_step = val;
         CSR_WRAP_ENABLE:  m_wrap_en = val[0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic mode, logic [12:0] minl, logic [15:0] off,
                             logic [15:0] gain, logic [15:0] rad, logic [15:0] step,
                             logic wen);
      csr_write(CSR_COMPARE_MODE, {15'd0, mode});
      csr_write(CSR_MIN_LENGTH, {3'd0, minl});
      csr_write(CSR_OFFSET_MM, off);
      csr_write(CSR_GAIN_Q16, gain);
      csr_write(CSR_RADIUS_MM, rad);
      csr_write(CSR_FIXED_STEP, step);
      csr_write(CSR_WRAP_ENABLE, {15'd0, wen});
   endtask

   task automatic add_beam(logic [15:0] r, logic [15:0] b, logic last);
      beam_type bm;
      bm.range_mm = r;
      bm.bearing = b;
      bm.scan_end = last;
      beam_q.insert(beam_q.size(), bm);
   endtask

   // clustered scan: smooth runs, jumps, invalid beams and some noise
   task automatic rand_scan(int n);
      int          base, first, r;
      logic [15:0] b, step;
      base = $urandom_range(200, 30000);
      first = base;
      b = 16'($urandom);
      step = 16'($urandom_range(1, 600));
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0, 1: r = 0;
            2, 3: begin base = $urandom_range(1, 65535); r = base; end
            4:    begin r = int'($urandom); b = 16'($urandom); end
            default: begin
               if (i >= n - 3 && $urandom_range(0, 2) == 0) base = first;
               r = base + $signed($urandom_range(0, base / 8 + 2)) - base / 16 - 1;
               if (r < 1) r = 1;
               if (r > 65535) r = 65535;
            end
         endcase
         add_beam(r[15:0], b, i == n - 1);
         b = b + step;
      end
   endtask

   // wait until every beam is sent and every record has come, then let it settle
   task automatic drain();
      do @(posedge clock); while (beam_q.size() != 0 || req_tvalid || record_q.size() != 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic random_phase(int items);
      int done;
      done = 0;
      while (done < items) begin
         int n;
         n = $urandom_range(1, 14);
         rand_scan(n);
         done += n;
      end
      drain();
   endtask

   initial begin
      fill_trig();
      m_mode = MODE_LINEAR; m_min_len = MIN_LENGTH_RST; m_offset = OFFSET_RST;
      m_gain = GAIN_RST; m_radius = RADIUS_RST; m_step = '0; m_wrap_en = 1'b0;
      s_prev_r = '0; s_prev_b = '0; s_head_r = '0; s_head_b = '0;
      s_tail_r = '0; s_tail_b = '0;
      s_count = 0; s_open_start = 0; s_open_len = 0; s_kept = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, field extremes, invalid beams, single-beam scans
      add_beam(16'd0, 16'd0, 1'b0);
      add_beam(16'hFFFF, 16'hFFFF, 1'b0);
      add_beam(16'hFFFF, 16'h0000, 1'b0);
      add_beam(16'd1, 16'd100, 1'b0);
      add_beam(16'd1000, 16'd200, 1'b0);
      add_beam(16'd1050, 16'd300, 1'b1);
      add_beam(16'd500, 16'd7, 1'b1);
      add_beam(16'd0, 16'hFFFF, 1'b1);
      drain();
      set_config(MODE_LINEAR, 13'd2, 16'd50, 16'd3000, 16'd100, 16'd0, 1'b1);
      add_beam(16'd2000, 16'd65500, 1'b0);
      add_beam(16'd2010, 16'd65530, 1'b0);
      add_beam(16'd9000, 16'd20, 1'b0);
      add_beam(16'd9000, 16'd40, 1'b0);
      add_beam(16'd2005, 16'd60, 1'b0);
      add_beam(16'd2000, 16'd80, 1'b1);
      drain();
      set_config(MODE_CIRCLE, 13'd1, 16'd0, 16'd0, 16'd400, 16'd0, 1'b1);
      add_beam(16'd3000, 16'd0, 1'b0);
      add_beam(16'd3020, 16'd150, 1'b0);
      add_beam(16'd3500, 16'd300, 1'b0);
      add_beam(16'd3490, 16'd450, 1'b0);
      add_beam(16'd3000, 16'hFFF0, 1'b1);
      drain();

      // random phases over several settings, extremes among them
      random_phase(60);
      set_config(MODE_LINEAR, 13'd3, 16'd0, 16'hFFFF, 16'd0, 16'd0, 1'b1);
      random_phase(50);
      set_config(MODE_LINEAR, 13'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b1);
      random_phase(30);
      // long receiver hold while beams keep coming
      set_config(MODE_CIRCLE, 13'd1, 16'd0, 16'd0, 16'hFFFF, 16'd0, 1'b1);
      hold_req = 1'b1;
      random_phase(60);
      set_config(MODE_CIRCLE, 13'd2, 16'd0, 16'd0, 16'd0, 16'd256, 1'b1);
      random_phase(30);
      set_config(MODE_CIRCLE, 13'd1, 16'd0, 16'd0, 16'd1500, 16'd300, 1'b0);
      random_phase(40);
      set_config(MODE_LINEAR, 13'h1FFF, 16'd100, 16'd6554, 16'd100, 16'd0, 1'b1);
      random_phase(30);

      // quiet closing phase
      quiet = 1'b1;
      set_config(MODE_LINEAR, 13'd1, 16'd100, 16'd6554, 16'd100, 16'd0, 1'b1);
      random_phase(60);

      if (fails == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // overall time limit
   initial begin
      #15ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/lrjs_pkg.sv
sv/lrjs_test_unit.sv
sv/lidar_range_jump_segmenter.sv
tb/sv/lidar_range_jump_segmenter_tb.sv
